FILE: hdl/spmgc_pkg.sv
// Package for the sorted point table with largest-gap cost.
// Holds the status codes, the controller command struct and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package spmgc_pkg;

	localparam int COST_W   = 30;
	localparam int COUNT_W  = 9;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2,
		ST_DUP    = 2'd3
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;  // latch the incoming item
		logic compare;  // compare coordinate against all cells
		logic update;   // shift cells, update count and status
		logic load;     // load the result register from the gap tree root
	} cmd_t;

endpackage

FILE: hdl/spmgc_ctrl.sv
// Controller for the sorted point table: sequences compare, update,
// gap tree settle and result load. Depends on spmgc_pkg.
`timescale 1ns / 1ps

module spmgc_ctrl #(
	parameter int TREE_LVL = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output spmgc_pkg::cmd_t  cmd
);

	localparam int WW = $clog2(TREE_LVL + 2);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_UPD,
		S_WAIT,
		S_FIN
	} state_t;

	state_t          state_q;
	logic [WW-1:0]   wait_q;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free   = !out_valid_q || out_ready;
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;

	// command decode
	always_comb begin
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.compare = (state_q == S_CMP);
		cmd.update  = (state_q == S_UPD);
		cmd.load    = (state_q == S_FIN) && slot_free;
	end

	// state, settle counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					wait_q  <= '0;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					wait_q <= wait_q + WW'(1);
					if (wait_q == WW'(TREE_LVL))
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/spmgc_dp.sv
// Datapath for the sorted point table: a row of sorted cells, the
// registered max-gap tree and the result register. Depends on spmgc_pkg.
`timescale 1ns / 1ps

module spmgc_dp #(
	parameter int CAPACITY   = 256,
	parameter int COORD_BITS = 30,
	parameter int TREE_LVL   = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  spmgc_pkg::cmd_t                  cmd,
	input  logic                             kind,
	input  logic [COORD_BITS-1:0]            coordinate,
	output logic [spmgc_pkg::COST_W-1:0]     cost,
	output logic [spmgc_pkg::COUNT_W-1:0]    point_count,
	output spmgc_pkg::status_t               status
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int NL = 1 << TREE_LVL;

	logic                   kind_q;
	logic [COORD_BITS-1:0]  x_q;
	logic [COORD_BITS-1:0]  pts_q [CAPACITY];
	logic [COORD_BITS-1:0]  pts_nx [CAPACITY];
	logic [CAPACITY-1:0]    lt_q;
	logic [CAPACITY-1:0]    lt_sh;
	logic                   present_q;
	logic                   hit;
	logic [CW-1:0]          cnt_q;
	spmgc_pkg::status_t     st_q;
	logic                   do_ins;
	logic                   do_rem;

	// heap-ordered tree, node 1 is the root, leaves start at NL
	logic [COORD_BITS-1:0]  gap_q [1:2*NL-1];
	logic [COORD_BITS-1:0]  top_q [1:2*NL-1];

	logic [COORD_BITS-1:0]  diff;
	logic [COORD_BITS+spmgc_pkg::COST_W-1:0]  cost_ext;
	logic [CW+spmgc_pkg::COUNT_W-1:0]         cnt_ext;

	assign lt_sh  = {lt_q[CAPACITY-2:0], 1'b1};
	assign do_ins = !kind_q && !present_q && (cnt_q != CW'(CAPACITY));
	assign do_rem = kind_q && present_q;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			x_q    <= coordinate;
		end
	end

	// any held cell equal to x
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			if ((cnt_q > CW'(i)) && (pts_q[i] == x_q))
				hit = 1'b1;
		end
	end

	// per-cell compare: below-x flags form a prefix of the held cells
	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			present_q <= hit;
			for (int i = 0; i < CAPACITY; i++)
				lt_q[i] <= (cnt_q > CW'(i)) && (pts_q[i] < x_q);
		end
	end

	// next cell contents: shift right on insert, left on remove
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			pts_nx[i] = pts_q[i];
			if (do_ins && !lt_q[i]) begin
				if (lt_sh[i])
					pts_nx[i] = x_q;
				else if (i > 0)
					pts_nx[i] = pts_q[i-1];
			end else if (do_rem && !lt_q[i] && (i < CAPACITY - 1)) begin
				pts_nx[i] = pts_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update)
			pts_q <= pts_nx;
	end

	// count and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.update) begin
			if (do_ins)
				cnt_q <= cnt_q + CW'(1);
			else if (do_rem)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (!kind_q) begin
				if (present_q)
					st_q <= spmgc_pkg::ST_DUP;
				else if (cnt_q == CW'(CAPACITY))
					st_q <= spmgc_pkg::ST_FULL;
				else
					st_q <= spmgc_pkg::ST_OK;
			end else begin
				st_q <= present_q ? spmgc_pkg::ST_OK : spmgc_pkg::ST_ABSENT;
			end
		end
	end

	// gap tree: leaves hold the gap to the next held cell and the span at the
	// last held cell; nodes take the max of gaps and the OR of spans
	always_ff @(posedge clk) begin
		for (int i = 0; i < NL; i++) begin
			if ((i < CAPACITY - 1) && (cnt_q > CW'(i + 1)))
				gap_q[NL+i] <= pts_q[i+1] - pts_q[i];
			else
				gap_q[NL+i] <= '0;
			if ((i < CAPACITY) && (cnt_q == CW'(i + 1)))
				top_q[NL+i] <= pts_q[i] - pts_q[0];
			else
				top_q[NL+i] <= '0;
		end
		for (int k = 1; k < NL; k++) begin
			gap_q[k] <= (gap_q[2*k] > gap_q[2*k+1]) ? gap_q[2*k] : gap_q[2*k+1];
			top_q[k] <= top_q[2*k] | top_q[2*k+1];
		end
	end

	// result register
	assign diff     = top_q[1] - gap_q[1];
	assign cost_ext = {{spmgc_pkg::COST_W{1'b0}}, diff};
	assign cnt_ext  = {{spmgc_pkg::COUNT_W{1'b0}}, cnt_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cost        <= (cnt_q <= CW'(2)) ? '0 : cost_ext[spmgc_pkg::COST_W-1:0];
			point_count <= cnt_ext[spmgc_pkg::COUNT_W-1:0];
			status      <= st_q;
		end
	end

endmodule

FILE: hdl/sorted_points_max_gap_cost.sv
// Sorted point table with largest-gap cost: top level.
// Instantiates spmgc_ctrl and spmgc_dp; depends on spmgc_pkg.
//
// Usage:
//  Input channel s_axis: one item inserts (tuser 0) or removes (tuser 1)
//  the coordinate in tdata. Output channel m_axis: one result item per input
//  item carrying cost, point count after the item, and a status code.
//  Points are held in a row of sorted cells, one register per entry;
//  the largest gap and the span are found by a registered tree over the cells.
//  After an item is accepted, the controller steps through compare, cell
//  update, a wait for the gap tree to settle (set by its depth) and result
//  load. One item is worked at a time; s_axis_tready rises again at the
//  edge that loads the result.
//  The result sits in an output register: a new item is taken while an old
//  result waits; if m_axis stalls, the next result holds in its final step
//  until the register frees up.
//  Reset clears the point count and all handshake state; the table is empty.
`timescale 1ns / 1ps

module sorted_points_max_gap_cost #(
	parameter int CAPACITY   = 256,
	parameter int COORD_BITS = 30
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,  // coordinate
	input  logic                                  s_axis_tuser,  // kind
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [47:0]                           m_axis_tdata   // cost, point_count, status
);

	localparam int TREE_LVL = $clog2(CAPACITY);

	spmgc_pkg::cmd_t                   cmd;
	logic [spmgc_pkg::COST_W-1:0]      cost;
	logic [spmgc_pkg::COUNT_W-1:0]     point_count;
	spmgc_pkg::status_t                status;

	spmgc_ctrl #(
		.TREE_LVL (TREE_LVL)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	spmgc_dp #(
		.CAPACITY   (CAPACITY),
		.COORD_BITS (COORD_BITS),
		.TREE_LVL   (TREE_LVL)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (s_axis_tuser),
		.coordinate  (s_axis_tdata[COORD_BITS-1:0]),
		.cost        (cost),
		.point_count (point_count),
		.status      (status)
	);

	// pack result: cost [29:0], point_count [38:30], status [40:39]
	assign m_axis_tdata = {7'd0, status, point_count, cost};

endmodule

FILE: hdl/spmgc_chk.sv
// Port-level checker for the sorted point table, bound to the top level.
// Depends on spmgc_pkg for status codes.
`timescale 1ns / 1ps

module spmgc_chk #(
	parameter int CAPACITY = 256
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);

	// a stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// one item in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while busy");

	// count never exceeds the table (count field wraps on very large tables)
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (CAPACITY > 511) || (m_axis_tdata[38:30] <= 9'(CAPACITY)))
		else $error("point count beyond capacity");

	// full status only with a full table
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[40:39] == spmgc_pkg::ST_FULL
		|-> m_axis_tdata[38:30] == 9'(CAPACITY))
		else $error("full status with room left");

	// two or fewer points give zero cost
	a_small: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[38:30] <= 9'd2 |-> m_axis_tdata[29:0] == 30'd0)
		else $error("nonzero cost with two or fewer points");

endmodule

bind sorted_points_max_gap_cost spmgc_chk #(
	.CAPACITY (CAPACITY)
) u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
